FILE: src/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg - shared types and constants
// Holds the widths, the item kinds and the structs used between the
// ray/triangle intersection modules.
// ----------------------------------------------------------------------------
package rti_pkg;

   localparam int COORD_W   = 21;  // internal coordinate width (sign extended)
   localparam int SLOT_W    = 10;
   localparam int XYZ_W     = 63;
   localparam int EPS_W     = 16;
   localparam int DIFF_W    = 22;  // edge and offset vectors
   localparam int PROD_W    = 44;  // cross product partial terms
   localparam int CROSS_W   = 45;  // cross product before the drop
   localparam int DROP_BITS = 6;
   localparam int VEC_W     = CROSS_W - DROP_BITS;  // p and q
   localparam int DOTP_W    = 61;  // dot product partial terms
   localparam int DOT_W     = 63;  // dot product sums
   localparam int DIV_STEPS = 32;  // quotient bits per division
   localparam int DIST_W    = 32;
   localparam int BARY_W    = 17;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_TEST = 1'b1
   } kind_type;

   // transaction tag travelling alongside the arithmetic
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot_a;
      logic [SLOT_W-1:0] slot_b;
      logic [SLOT_W-1:0] slot_c;
   } tag_type;

   // geometry result handed to the dividers
   typedef struct packed {
      tag_type          tag;
      logic             pre_hit;
      logic [DOT_W-1:0] den;
      logic [DOT_W-1:0] un;
      logic [DOT_W-1:0] vn;
      logic [DOT_W-1:0] tn;
   } geom_type;

   // status carried in step with the dividers
   typedef struct packed {
      tag_type tag;
      logic    pre_hit;
      logic    sat;
   } side_type;

endpackage

FILE: src/rti_vertex_store.sv
// ----------------------------------------------------------------------------
// rti_vertex_store - packed vertex memory
// Three copies of the store, written together, each read at one corner
// address with a registered read.
// ----------------------------------------------------------------------------
module rti_vertex_store
   import rti_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [XYZ_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr [3],
   output logic [XYZ_W-1:0]  rd_data [3]
);

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_bank
         logic [XYZ_W-1:0] mem [DEPTH];
         logic [XYZ_W-1:0] rd_ff;

         // write every copy, read one corner per copy
         always_ff @(posedge clock) begin
            if (wr_en) begin
               mem[wr_addr] <= wr_data;
            end
            rd_ff <= mem[rd_addr[g]];
         end

         assign rd_data[g] = rd_ff;
      end
   endgenerate

endmodule

FILE: src/rti_geom.sv
// ----------------------------------------------------------------------------
// rti_geom - Moller-Trumbore geometry pipeline
// Six stages: edges, cross terms, cross drop, dot terms, dot sums, sign
// fold and hit pre-checks.
// ----------------------------------------------------------------------------
module rti_geom
   import rti_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [EPS_W-1:0]          epsilon,
   input  tag_type                   tag,
   input  logic signed [COORD_W-1:0] vert_a [3],
   input  logic signed [COORD_W-1:0] vert_b [3],
   input  logic signed [COORD_W-1:0] vert_c [3],
   input  logic signed [COORD_W-1:0] orig   [3],
   input  logic signed [COORD_W-1:0] dir    [3],
   output geom_type                  geom
);

   tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff;

   logic signed [DIFF_W-1:0] e1_1_ff [3], e2_1_ff [3], s_1_ff [3], d_1_ff [3];
   logic signed [DIFF_W-1:0] e1_2_ff [3], e2_2_ff [3], s_2_ff [3], d_2_ff [3];
   logic signed [DIFF_W-1:0] e1_3_ff [3], e2_3_ff [3], s_3_ff [3], d_3_ff [3];
   logic signed [PROD_W-1:0] pa_ff [3], pb_ff [3], qa_ff [3], qb_ff [3];
   logic signed [CROSS_W-1:0] p_full [3], q_full [3];
   logic signed [VEC_W-1:0]   p_ff [3], q_ff [3];
   logic signed [DOTP_W-1:0]  al_ff [3], un_ff [3], vn_ff [3], tn_ff [3];
   logic signed [DOT_W-1:0]   alpha_ff, usum_ff, vsum_ff, tsum_ff;

   logic             neg;
   logic [DOT_W-1:0] den_in, un_in, vn_in, tn_in;
   logic             pre_in;
   geom_type         geom_ff;

   // advance the tag
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
         tag5_ff <= '0;
      end else begin
         tag1_ff <= tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
         tag5_ff <= tag4_ff;
      end
   end

   // form the edges and the origin offset, then the cross terms
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         e1_1_ff[i] <= DIFF_W'(vert_b[i]) - DIFF_W'(vert_a[i]);
         e2_1_ff[i] <= DIFF_W'(vert_c[i]) - DIFF_W'(vert_a[i]);
         s_1_ff[i]  <= DIFF_W'(orig[i]) - DIFF_W'(vert_a[i]);
         d_1_ff[i]  <= DIFF_W'(dir[i]);
         pa_ff[i]   <= d_1_ff[(i + 1) % 3] * e2_1_ff[(i + 2) % 3];
         pb_ff[i]   <= d_1_ff[(i + 2) % 3] * e2_1_ff[(i + 1) % 3];
         qa_ff[i]   <= s_1_ff[(i + 1) % 3] * e1_1_ff[(i + 2) % 3];
         qb_ff[i]   <= s_1_ff[(i + 2) % 3] * e1_1_ff[(i + 1) % 3];
         e1_2_ff[i] <= e1_1_ff[i];
         e2_2_ff[i] <= e2_1_ff[i];
         s_2_ff[i]  <= s_1_ff[i];
         d_2_ff[i]  <= d_1_ff[i];
      end
   end

   // subtract the cross terms
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_full[i] = CROSS_W'(pa_ff[i]) - CROSS_W'(pb_ff[i]);
         q_full[i] = CROSS_W'(qa_ff[i]) - CROSS_W'(qb_ff[i]);
      end
   end

   // drop the low bits (floor), then the dot terms and their sums
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         p_ff[i]    <= p_full[i][CROSS_W-1:DROP_BITS];
         q_ff[i]    <= q_full[i][CROSS_W-1:DROP_BITS];
         e1_3_ff[i] <= e1_2_ff[i];
         e2_3_ff[i] <= e2_2_ff[i];
         s_3_ff[i]  <= s_2_ff[i];
         d_3_ff[i]  <= d_2_ff[i];
         al_ff[i]   <= e1_3_ff[i] * p_ff[i];
         un_ff[i]   <= s_3_ff[i] * p_ff[i];
         vn_ff[i]   <= d_3_ff[i] * q_ff[i];
         tn_ff[i]   <= e2_3_ff[i] * q_ff[i];
      end
      alpha_ff <= DOT_W'(al_ff[0]) + DOT_W'(al_ff[1]) + DOT_W'(al_ff[2]);
      usum_ff  <= DOT_W'(un_ff[0]) + DOT_W'(un_ff[1]) + DOT_W'(un_ff[2]);
      vsum_ff  <= DOT_W'(vn_ff[0]) + DOT_W'(vn_ff[1]) + DOT_W'(vn_ff[2]);
      tsum_ff  <= DOT_W'(tn_ff[0]) + DOT_W'(tn_ff[1]) + DOT_W'(tn_ff[2]);
   end

   // fold the determinant sign and check the hit bounds
   always_comb begin
      neg    = alpha_ff[DOT_W-1];
      den_in = neg ? DOT_W'(-alpha_ff) : DOT_W'(alpha_ff);
      un_in  = neg ? DOT_W'(-usum_ff) : DOT_W'(usum_ff);
      vn_in  = neg ? DOT_W'(-vsum_ff) : DOT_W'(vsum_ff);
      tn_in  = neg ? DOT_W'(-tsum_ff) : DOT_W'(tsum_ff);
      pre_in = (den_in != '0)
             && (den_in >= DOT_W'({epsilon, 14'b0}))
             && !un_in[DOT_W-1] && !vn_in[DOT_W-1] && !tn_in[DOT_W-1]
             && ((64'(un_in) + 64'(vn_in)) <= 64'(den_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.tag <= '0;
      end else begin
         geom_ff.tag <= tag5_ff;
      end
      geom_ff.pre_hit <= pre_in;
      geom_ff.den     <= den_in;
      geom_ff.un      <= un_in;
      geom_ff.vn      <= vn_in;
      geom_ff.tn      <= tn_in;
   end

   assign geom = geom_ff;

endmodule

FILE: src/rti_divider.sv
// ----------------------------------------------------------------------------
// rti_divider - pipelined restoring divider
// Gives floor(num * 2^16 / den) one quotient bit per stage, for quotients
// below 2^32.
// ----------------------------------------------------------------------------
module rti_divider
   import rti_pkg::*;
(
   input  logic              clock,
   input  logic [DOT_W-1:0]  num,
   input  logic [DOT_W-1:0]  den,
   output logic [DIV_STEPS-1:0] quot
);

   logic [DOT_W-1:0]     rem_ff  [DIV_STEPS];
   logic [DOT_W-1:0]     den_ff  [DIV_STEPS];
   logic [DIV_STEPS-1:0] bits_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] q_ff    [DIV_STEPS];

   genvar g;
   generate
      for (g = 0; g < DIV_STEPS; g++) begin : g_step
         logic [DOT_W-1:0]     rem_prev;
         logic [DOT_W-1:0]     den_prev;
         logic [DIV_STEPS-1:0] bits_prev;
         logic [DIV_STEPS-1:0] q_prev;
         logic [DOT_W:0]       trial;
         logic                 take;

         // the top bits of the scaled dividend stay below den
         if (g == 0) begin : g_first
            assign rem_prev  = DOT_W'(num[DOT_W-1:16]);
            assign den_prev  = den;
            assign bits_prev = {num[15:0], 16'b0};
            assign q_prev    = '0;
         end else begin : g_next
            assign rem_prev  = rem_ff[g-1];
            assign den_prev  = den_ff[g-1];
            assign bits_prev = bits_ff[g-1];
            assign q_prev    = q_ff[g-1];
         end

         // shift in one dividend bit and try the subtract
         assign trial = {rem_prev, bits_prev[DIV_STEPS-1]};
         assign take  = trial >= {1'b0, den_prev};

         always_ff @(posedge clock) begin
            rem_ff[g]  <= take ? DOT_W'(trial - {1'b0, den_prev}) : trial[DOT_W-1:0];
            den_ff[g]  <= den_prev;
            bits_ff[g] <= {bits_prev[DIV_STEPS-2:0], 1'b0};
            q_ff[g]    <= {q_prev[DIV_STEPS-2:0], take};
         end
      end
   endgenerate

   assign quot = q_ff[DIV_STEPS-1];

endmodule

FILE: src/ray_triangle_intersection_core.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersection_core - ray/triangle intersection with vertex store
// Loads packed vertices into a store and answers ray tests with the
// Moller-Trumbore hit flag, distance and barycentrics.
//
//   channel  ports              handshake
//   request  start, busy, req_* taken when start is high and busy low
//   response rsp_valid, rsp_*   one-cycle strobe, cannot be held off
//   control  csr_write_*        written when csr_write_enable is high
//
// One transaction is taken every cycle; busy never rises.
// A test result passes the store read, the geometry pipeline, the
// one-bit-per-stage dividers and the output register. A load gives no
// response.
// Reset clears the pipeline valids and sets epsilon to 1; the vertex store
// is not cleared.
// ----------------------------------------------------------------------------
module ray_triangle_intersection_core
   import rti_pkg::*;
#(
   parameter int VERTEX_SLOTS = 1024,
   parameter int COORD_BITS   = 21
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_kind,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [XYZ_W-1:0]    req_vertex_xyz,
   input  logic [XYZ_W-1:0]    req_ray_origin,
   input  logic [XYZ_W-1:0]    req_ray_dir,
   input  logic [SLOT_W-1:0]   req_corner_a,
   input  logic [SLOT_W-1:0]   req_corner_b,
   input  logic [SLOT_W-1:0]   req_corner_c,
   output logic                rsp_valid,
   output logic                rsp_is_hit,
   output logic [DIST_W-1:0]   rsp_distance,
   output logic [BARY_W-1:0]   rsp_bary_u,
   output logic [BARY_W-1:0]   rsp_bary_v,
   output logic [SLOT_W-1:0]   rsp_echo_a,
   output logic [SLOT_W-1:0]   rsp_echo_b,
   output logic [SLOT_W-1:0]   rsp_echo_c,
   input  logic                csr_write_enable,
   input  logic [EPS_W-1:0]    csr_write_data
);

   localparam int ADDR_W = $clog2(VERTEX_SLOTS);

   logic               accept;
   logic [ADDR_W-1:0]  rd_addr [3];
   logic [XYZ_W-1:0]   rd_data [3];
   logic               wr_en;
   logic [EPS_W-1:0]   epsilon_ff;
   tag_type            tag0_ff;
   logic [2:0]         in_range_ff;
   logic [XYZ_W-1:0]   orig_ff, dir_ff;
   logic [XYZ_W-1:0]   corner_xyz [3];

   logic signed [COORD_W-1:0] vert [3][3];
   logic signed [COORD_W-1:0] orig_c [3], dir_c [3];

   geom_type              geom;
   logic [DIV_STEPS-1:0]  q_t, q_u, q_v;
   side_type              side_ff [DIV_STEPS];
   side_type              side_last;
   logic                  sat_in;
   logic [DIST_W-1:0]     t_dist;
   logic                  hit;

   logic                  rsp_valid_ff, rsp_hit_ff;
   logic [DIST_W-1:0]     rsp_dist_ff;
   logic [BARY_W-1:0]     rsp_u_ff, rsp_v_ff;
   logic [SLOT_W-1:0]     rsp_a_ff, rsp_b_ff, rsp_c_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign wr_en  = accept && (req_kind == KIND_LOAD)
                && (17'(req_slot) < 17'(VERTEX_SLOTS));

   assign rd_addr[0] = ADDR_W'(req_corner_a);
   assign rd_addr[1] = ADDR_W'(req_corner_b);
   assign rd_addr[2] = ADDR_W'(req_corner_c);

   // hold epsilon
   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff <= EPS_W'(1);
      end else if (csr_write_enable) begin
         epsilon_ff <= csr_write_data;
      end
   end

   rti_vertex_store #(
      .DEPTH  (VERTEX_SLOTS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_slot)),
      .wr_data (req_vertex_xyz),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // capture the test transaction alongside the store read
   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
      end else begin
         tag0_ff.valid  <= accept && (req_kind == KIND_TEST);
         tag0_ff.slot_a <= req_corner_a;
         tag0_ff.slot_b <= req_corner_b;
         tag0_ff.slot_c <= req_corner_c;
      end
      in_range_ff[0] <= 17'(req_corner_a) < 17'(VERTEX_SLOTS);
      in_range_ff[1] <= 17'(req_corner_b) < 17'(VERTEX_SLOTS);
      in_range_ff[2] <= 17'(req_corner_c) < 17'(VERTEX_SLOTS);
      orig_ff        <= req_ray_origin;
      dir_ff         <= req_ray_dir;
   end

   // corners beyond the store read as the origin point
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         corner_xyz[k] = in_range_ff[k] ? rd_data[k] : '0;
      end
   end

   // unpack and sign extend the coordinates
   genvar gk, gi;
   generate
      for (gi = 0; gi < 3; gi++) begin : g_axis
         logic signed [COORD_BITS-1:0] o_raw, d_raw;
         assign o_raw     = orig_ff[COORD_BITS*gi +: COORD_BITS];
         assign d_raw     = dir_ff[COORD_BITS*gi +: COORD_BITS];
         assign orig_c[gi] = COORD_W'(o_raw);
         assign dir_c[gi]  = COORD_W'(d_raw);
         for (gk = 0; gk < 3; gk++) begin : g_corner
            logic signed [COORD_BITS-1:0] v_raw;
            assign v_raw        = corner_xyz[gk][COORD_BITS*gi +: COORD_BITS];
            assign vert[gk][gi] = COORD_W'(v_raw);
         end
      end
   endgenerate

   rti_geom u_geom (
      .clock   (clock),
      .reset   (reset),
      .epsilon (epsilon_ff),
      .tag     (tag0_ff),
      .vert_a  (vert[0]),
      .vert_b  (vert[1]),
      .vert_c  (vert[2]),
      .orig    (orig_c),
      .dir     (dir_c),
      .geom    (geom)
   );

   rti_divider u_div_t (.clock(clock), .num(geom.tn), .den(geom.den), .quot(q_t));
   rti_divider u_div_u (.clock(clock), .num(geom.un), .den(geom.den), .quot(q_u));
   rti_divider u_div_v (.clock(clock), .num(geom.vn), .den(geom.den), .quot(q_v));

   // far hit: whole part of t would pass 16 bits
   assign sat_in = {16'b0, geom.tn} >= {geom.den, 16'b0};

   // advance the status in step with the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STEPS; i++) begin
            side_ff[i] <= '0;
         end
      end else begin
         side_ff[0] <= '{tag: geom.tag, pre_hit: geom.pre_hit, sat: sat_in};
         for (int i = 1; i < DIV_STEPS; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign side_last = side_ff[DIV_STEPS-1];
   assign t_dist    = side_last.sat ? '1 : q_t;
   assign hit       = side_last.pre_hit && (t_dist >= DIST_W'(epsilon_ff));

   // register the response; zero the distance and barycentrics on a miss
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= side_last.tag.valid;
      end
      rsp_hit_ff  <= hit;
      rsp_dist_ff <= hit ? t_dist : '0;
      rsp_u_ff    <= hit ? q_u[BARY_W-1:0] : '0;
      rsp_v_ff    <= hit ? q_v[BARY_W-1:0] : '0;
      rsp_a_ff    <= side_last.tag.slot_a;
      rsp_b_ff    <= side_last.tag.slot_b;
      rsp_c_ff    <= side_last.tag.slot_c;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_hit   = rsp_hit_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_bary_u   = rsp_u_ff;
   assign rsp_bary_v   = rsp_v_ff;
   assign rsp_echo_a   = rsp_a_ff;
   assign rsp_echo_b   = rsp_b_ff;
   assign rsp_echo_c   = rsp_c_ff;

endmodule
